[design/assert_macros.svh]
// Assertion macros shared by the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

[design/sqt_pkg.sv]
package sqt_pkg;

  localparam int unsigned MaxSourceBytes = 1048576;
  localparam int unsigned KeywordMaxChars = 7;
  localparam int unsigned NumKeywords = 21;
  localparam int unsigned MaxRecs = 4;
  localparam logic [20:0] CntMax = 21'h1FFFFF;

  typedef enum logic [4:0] {
    K_EOF = 5'd0, K_IDENT = 5'd1, K_KW = 5'd2, K_INT = 5'd3, K_FLOAT = 5'd4,
    K_STR = 5'd5, K_LPAREN = 5'd6, K_RPAREN = 5'd7, K_COMMA = 5'd8,
    K_SEMI = 5'd9, K_STAR = 5'd10, K_DOT = 5'd11, K_EQ = 5'd12, K_LT = 5'd13,
    K_LE = 5'd14, K_NE = 5'd15, K_GT = 5'd16, K_GE = 5'd17, K_UNK = 5'd18
  } kind_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       byte_valid;
    logic       end_of_source;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [4:0]  keyword_id;
    logic [19:0] start_offset;
    logic [20:0] token_length;
    logic [20:0] start_line;
    logic [20:0] start_column;
    logic        last_of_run;
  } rec_t;

  // One bundle of up to four records caused by one input transaction.
  typedef struct packed {
    logic [2:0]           count;
    rec_t [MaxRecs-1:0]   recs;
  } bundle_t;

  // Keyword id of a lowercased word of length len (0 when none).
  function automatic logic [4:0] keyword_lookup(input logic [55:0] w, input logic [2:0] len);
    logic [4:0] id;
    id = 5'd0;
    unique case (len)
      3'd2: begin
        if (w[15:0] == {"s", "a"}) id = 5'd2;
        else if (w[15:0] == {"f", "i"}) id = 5'd8;
        else if (w[15:0] == {"r", "o"}) id = 5'd14;
      end
      3'd3: begin
        if (w[23:0] == {"d", "n", "a"}) id = 5'd1;
        else if (w[23:0] == {"y", "e", "k"}) id = 5'd11;
        else if (w[23:0] == {"t", "o", "n"}) id = 5'd12;
      end
      3'd4: begin
        if (w[31:0] == {"m", "o", "r", "f"}) id = 5'd7;
        else if (w[31:0] == {"o", "t", "n", "i"}) id = 5'd10;
        else if (w[31:0] == {"l", "l", "u", "n"}) id = 5'd13;
        else if (w[31:0] == {"e", "u", "r", "t"}) id = 5'd18;
      end
      3'd5: begin
        if (w[39:0] == {"e", "s", "l", "a", "f"}) id = 5'd6;
        else if (w[39:0] == {"e", "l", "b", "a", "t"}) id = 5'd17;
        else if (w[39:0] == {"e", "r", "e", "h", "w"}) id = 5'd21;
      end
      3'd6: begin
        if (w[47:0] == {"e", "t", "a", "e", "r", "c"}) id = 5'd3;
        else if (w[47:0] == {"s", "t", "s", "i", "x", "e"}) id = 5'd5;
        else if (w[47:0] == {"t", "r", "e", "s", "n", "i"}) id = 5'd9;
        else if (w[47:0] == {"t", "c", "e", "l", "e", "s"}) id = 5'd16;
        else if (w[47:0] == {"e", "u", "q", "i", "n", "u"}) id = 5'd19;
        else if (w[47:0] == {"s", "e", "u", "l", "a", "v"}) id = 5'd20;
      end
      3'd7: begin
        if (w == {"t", "l", "u", "a", "f", "e", "d"}) id = 5'd4;
        else if (w == {"y", "r", "a", "m", "i", "r", "p"}) id = 5'd15;
      end
      default: id = 5'd0;
    endcase
    return id;
  endfunction

endpackage

[design/sqt_stream_if.sv]
interface sqt_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

[design/sql_query_tokenizer_core.sv]
// Streaming SQL tokenizer. One input transaction carries one source byte (or only an
// end marker) and is taken every cycle while the two-entry bundle queue has room; the
// front scan state machine classifies the byte in that cycle and pushes the 0 to 4 token
// records it causes as one bundle. The back drains one record per cycle while the output
// is ready, so the input rate is one byte per cycle whenever bytes average at most one
// record each; an end of source that flushes a token yields up to four records. Offsets
// are from 0, line and column from 1; every bundle's final record has last_of_run set.
`include "assert_macros.svh"
module sql_query_tokenizer_core #(
  parameter int unsigned MaxSourceBytes = sqt_pkg::MaxSourceBytes
) (
  input logic clk_i,
  input logic rst_ni,
  sqt_stream_if.sink   in_if,
  sqt_stream_if.source out_if
);
  logic push, full, empty, pop;
  sqt_pkg::bundle_t push_data, head;

  sqt_front #(.MaxSourceBytes(MaxSourceBytes)) u_front (
    .clk_i, .rst_ni, .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .in_item_i(in_if.payload), .push_o(push), .push_data_o(push_data), .full_i(full));

  sqt_queue #(.Depth(2)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data), .full_o(full),
    .empty_o(empty), .pop_i(pop), .head_o(head));

  sqt_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .head_i(head), .pop_o(pop),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .out_rec_o(out_if.payload));

  // Never push into a full queue, every queued bundle holds a record, and a pop sends last_of_run.
  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push && full)
  `ASSERT_IMPL(a_bundle_nonempty, clk_i, rst_ni, empty || head.count != 3'd0)
  `ASSERT_IMPL(a_pop_is_last, clk_i, rst_ni, !pop || out_if.payload.last_of_run)
endmodule

[design/sqt_front.sv]
// Front: scan state machine; turns one byte into a bundle of records.
module sqt_front #(
  parameter int unsigned MaxSourceBytes = sqt_pkg::MaxSourceBytes
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sqt_pkg::in_item_t in_item_i,
  output logic              push_o,
  output sqt_pkg::bundle_t  push_data_o,
  input  logic              full_i
);

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_INT, M_INT_DOT, M_FRAC, M_EXP, M_EXP_DIG, M_STR, M_STR_Q,
    M_DASH, M_SLASH, M_LCOMM, M_BLOCK, M_BLOCK_STAR, M_LT, M_GT
  } mode_e;

  localparam int unsigned PosW = $clog2(MaxSourceBytes + 1);

  mode_e        mode_q, mode_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [20:0]  line_q, line_d, col_q, col_d;
  logic [19:0]  toff_q, toff_d;
  logic [20:0]  tline_q, tline_d, tcol_q, tcol_d;
  logic [55:0]  word_q, word_d;
  logic         flt_q, flt_d;

  sqt_pkg::bundle_t b;
  logic [7:0] c;
  logic take, absorbed, isdig, isalp, isword;
  logic [20:0] plen;
  logic [7:0] lc;
  logic [20:0] pos21;

  assign in_ready_o = !full_i;
  assign take = in_valid_i && in_ready_o;
  assign c = in_item_i.byte_value;
  assign isdig = c >= "0" && c <= "9";
  assign isalp = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  assign isword = isalp || isdig || c == "_";
  assign lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  assign pos21 = 21'(pos_q);
  assign plen = pos21 - {1'b0, toff_q};

  function automatic sqt_pkg::rec_t mk(input logic [4:0] k, input logic [4:0] id,
      input logic [19:0] off, input logic [20:0] len, input logic [20:0] ln,
      input logic [20:0] cl);
    sqt_pkg::rec_t r;
    r = '{token_kind: k, keyword_id: id, start_offset: off, token_length: len,
          start_line: ln, start_column: cl, last_of_run: 1'b0};
    return r;
  endfunction

  function automatic logic [20:0] sat(input logic [21:0] v);
    return (v > {1'b0, sqt_pkg::CntMax}) ? sqt_pkg::CntMax : v[20:0];
  endfunction

  always_comb begin
    logic [4:0] kid;
    logic [20:0] il;
    logic [20:0] el;
    b = '0;
    mode_d = mode_q; pos_d = pos_q; line_d = line_q; col_d = col_q;
    toff_d = toff_q; tline_d = tline_q; tcol_d = tcol_q;
    word_d = word_q; flt_d = flt_q;
    absorbed = 1'b0;
    kid = 5'd0;
    il = plen - 21'd1;
    el = 21'd0;
    if (in_item_i.byte_valid && 32'(pos_q) < MaxSourceBytes) begin
      // Try to extend the pending token with this byte.
      unique case (mode_q)
        M_IDENT: if (isword) begin
          absorbed = 1'b1;
          if (plen < 21'(sqt_pkg::KeywordMaxChars)) word_d[plen[2:0]*8 +: 8] = lc;
        end
        M_INT: begin
          if (isdig) absorbed = 1'b1;
          else if (c == ".") begin absorbed = 1'b1; mode_d = M_INT_DOT; end
          else if (c == "e" || c == "E") begin
            absorbed = 1'b1; flt_d = 1'b1; mode_d = M_EXP;
          end
        end
        M_INT_DOT: if (isdig) begin absorbed = 1'b1; flt_d = 1'b1; mode_d = M_FRAC; end
        M_FRAC: begin
          if (isdig) absorbed = 1'b1;
          else if (c == "e" || c == "E") begin absorbed = 1'b1; mode_d = M_EXP; end
        end
        M_EXP: if (isdig || c == "+" || c == "-") begin
          absorbed = 1'b1; mode_d = M_EXP_DIG;
        end
        M_EXP_DIG: absorbed = isdig;
        M_STR: begin absorbed = 1'b1; if (c == "'") mode_d = M_STR_Q; end
        M_STR_Q: if (c == "'") begin absorbed = 1'b1; mode_d = M_STR; end
        M_DASH: if (c == "-") begin absorbed = 1'b1; mode_d = M_LCOMM; end
        M_SLASH: if (c == "*") begin absorbed = 1'b1; mode_d = M_BLOCK; end
        M_LCOMM: begin absorbed = 1'b1; if (c == "\n") mode_d = M_IDLE; end
        M_BLOCK: begin absorbed = 1'b1; if (c == "*") mode_d = M_BLOCK_STAR; end
        M_BLOCK_STAR: begin
          absorbed = 1'b1;
          if (c == "/") mode_d = M_IDLE;
          else if (c != "*") mode_d = M_BLOCK;
        end
        M_LT: if (c == "=" || c == ">") begin
          absorbed = 1'b1; mode_d = M_IDLE;
          b.recs[0] = mk((c == "=") ? sqt_pkg::K_LE : sqt_pkg::K_NE, 5'd0, toff_q,
                         plen + 21'd1, tline_q, tcol_q);
          b.count = 3'd1;
        end
        M_GT: if (c == "=") begin
          absorbed = 1'b1; mode_d = M_IDLE;
          b.recs[0] = mk(sqt_pkg::K_GE, 5'd0, toff_q, plen + 21'd1, tline_q, tcol_q);
          b.count = 3'd1;
        end
        M_IDLE: absorbed = 1'b0;
        default: absorbed = 1'b0;
      endcase
      if (!absorbed) begin
        mode_d = M_IDLE;
        flt_d = flt_q;
        word_d = word_q;
        // Flush the pending token, then start on this byte.
        unique case (mode_q)
          M_IDENT: begin
            kid = (plen <= 21'(sqt_pkg::KeywordMaxChars))
                ? sqt_pkg::keyword_lookup(word_q, plen[2:0]) : 5'd0;
            b.recs[0] = mk((kid != 0) ? sqt_pkg::K_KW : sqt_pkg::K_IDENT, kid, toff_q,
                           plen, tline_q, tcol_q);
            b.count = 3'd1;
          end
          M_INT, M_FRAC, M_EXP, M_EXP_DIG: begin
            b.recs[0] = mk(flt_q ? sqt_pkg::K_FLOAT : sqt_pkg::K_INT, 5'd0, toff_q, plen,
                           tline_q, tcol_q);
            b.count = 3'd1;
          end
          M_INT_DOT: begin
            b.recs[0] = mk(sqt_pkg::K_INT, 5'd0, toff_q, il, tline_q, tcol_q);
            b.recs[1] = mk(sqt_pkg::K_DOT, 5'd0, toff_q + il[19:0], 21'd1, tline_q,
                           sat({1'b0, tcol_q} + {1'b0, il}));
            b.count = 3'd2;
          end
          M_STR, M_STR_Q: begin
            b.recs[0] = mk(sqt_pkg::K_STR, 5'd0, toff_q, plen, tline_q, tcol_q);
            b.count = 3'd1;
          end
          M_DASH, M_SLASH: begin
            b.recs[0] = mk(sqt_pkg::K_UNK, 5'd0, toff_q, plen, tline_q, tcol_q);
            b.count = 3'd1;
          end
          M_LT: begin
            b.recs[0] = mk(sqt_pkg::K_LT, 5'd0, toff_q, plen, tline_q, tcol_q);
            b.count = 3'd1;
          end
          M_GT: begin
            b.recs[0] = mk(sqt_pkg::K_GT, 5'd0, toff_q, plen, tline_q, tcol_q);
            b.count = 3'd1;
          end
          default: b.count = 3'd0;
        endcase
        priority if (c == " " || c == "\t" || c == "\r" || c == "\n") begin
          mode_d = M_IDLE;
        end else if (c == "(" || c == ")" || c == "," || c == ";" || c == "*" ||
                     c == "." || c == "=" || !(isalp || isdig || c == "_" ||
                     c == "<" || c == ">" || c == "-" || c == "/" || c == "'")) begin
          b.recs[b.count[1:0]] = mk(
              (c == "(") ? sqt_pkg::K_LPAREN : (c == ")") ? sqt_pkg::K_RPAREN :
              (c == ",") ? sqt_pkg::K_COMMA : (c == ";") ? sqt_pkg::K_SEMI :
              (c == "*") ? sqt_pkg::K_STAR : (c == ".") ? sqt_pkg::K_DOT :
              (c == "=") ? sqt_pkg::K_EQ : sqt_pkg::K_UNK,
              5'd0, pos_q[19:0], 21'd1, line_q, col_q);
          b.count = b.count + 3'd1;
        end else begin
          toff_d = pos_q[19:0]; tline_d = line_q; tcol_d = col_q;
          priority if (c == "<") mode_d = M_LT;
          else if (c == ">") mode_d = M_GT;
          else if (c == "-") mode_d = M_DASH;
          else if (c == "/") mode_d = M_SLASH;
          else if (c == "'") mode_d = M_STR;
          else if (isdig) begin mode_d = M_INT; flt_d = 1'b0; end
          else begin mode_d = M_IDENT; word_d = {48'd0, lc}; end
        end
      end
      pos_d = pos_q + PosW'(1);
      if (c == "\n") begin
        line_d = sat({1'b0, line_q} + 22'd1); col_d = 21'd1;
      end else begin
        col_d = sat({1'b0, col_q} + 22'd1);
      end
    end
    if (in_item_i.end_of_source) begin
      // Flush whatever is pending in the updated mode, then Eof.
      el = 21'(pos_d) - {1'b0, toff_d};
      unique case (mode_d)
        M_IDENT: begin
          kid = (el <= 21'(sqt_pkg::KeywordMaxChars))
              ? sqt_pkg::keyword_lookup(word_d, el[2:0]) : 5'd0;
          b.recs[b.count[1:0]] = mk((kid != 0) ? sqt_pkg::K_KW : sqt_pkg::K_IDENT, kid,
              toff_d, el, tline_d, tcol_d);
          b.count = b.count + 3'd1;
        end
        M_INT, M_FRAC, M_EXP, M_EXP_DIG: begin
          b.recs[b.count[1:0]] = mk(flt_d ? sqt_pkg::K_FLOAT : sqt_pkg::K_INT, 5'd0,
              toff_d, el, tline_d, tcol_d);
          b.count = b.count + 3'd1;
        end
        M_INT_DOT: begin
          il = el - 21'd1;
          b.recs[b.count[1:0]] = mk(sqt_pkg::K_INT, 5'd0, toff_d, il, tline_d, tcol_d);
          b.recs[2'(b.count + 3'd1)] = mk(sqt_pkg::K_DOT, 5'd0, toff_d + il[19:0], 21'd1,
              tline_d, sat({1'b0, tcol_d} + {1'b0, il}));
          b.count = b.count + 3'd2;
        end
        M_STR, M_STR_Q, M_DASH, M_SLASH, M_LT, M_GT: begin
          b.recs[b.count[1:0]] = mk(
              (mode_d == M_STR || mode_d == M_STR_Q) ? sqt_pkg::K_STR :
              (mode_d == M_LT) ? sqt_pkg::K_LT : (mode_d == M_GT) ? sqt_pkg::K_GT :
              sqt_pkg::K_UNK, 5'd0, toff_d, el, tline_d, tcol_d);
          b.count = b.count + 3'd1;
        end
        default: b.count = b.count;
      endcase
      b.recs[b.count[1:0]] = mk(sqt_pkg::K_EOF, 5'd0, 20'd0, 21'd0, line_d, col_d);
      b.count = b.count + 3'd1;
      mode_d = M_IDLE; pos_d = '0; line_d = 21'd1; col_d = 21'd1;
      toff_d = '0; tline_d = 21'd1; tcol_d = 21'd1; word_d = '0; flt_d = 1'b0;
    end
    if (b.count != 3'd0) b.recs[2'(b.count - 3'd1)].last_of_run = 1'b1;
  end

  assign push_o = take && (b.count != 3'd0);
  assign push_data_o = b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE; pos_q <= '0; line_q <= 21'd1; col_q <= 21'd1;
      toff_q <= '0; tline_q <= 21'd1; tcol_q <= 21'd1; word_q <= '0; flt_q <= 1'b0;
    end else if (take) begin
      mode_q <= mode_d; pos_q <= pos_d; line_q <= line_d; col_q <= col_d;
      toff_q <= toff_d; tline_q <= tline_d; tcol_q <= tcol_d; word_q <= word_d;
      flt_q <= flt_d;
    end
  end

endmodule

[design/sqt_queue.sv]
// Short bundle queue between front and back.
module sqt_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sqt_pkg::bundle_t push_data_i,
  output logic             full_o,
  output logic             empty_o,
  input  logic             pop_i,
  output sqt_pkg::bundle_t head_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  sqt_pkg::bundle_t mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;

  assign full_o = cnt_q == (AW+1)'(Depth);
  assign empty_o = cnt_q == '0;
  assign head_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + AW'(1);
      if (pop_i) rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end
endmodule

[design/sqt_back.sv]
// Back: serialize a bundle into single record transactions.
module sqt_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  sqt_pkg::bundle_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sqt_pkg::rec_t    out_rec_o
);
  logic [1:0] idx_q;
  logic fire, last;

  assign out_valid_o = !empty_i;
  assign out_rec_o = head_i.recs[idx_q];
  assign fire = out_valid_o && out_ready_i;
  assign last = (3'(idx_q) + 3'd1) == head_i.count;
  assign pop_o = fire && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= '0;
    else if (fire) idx_q <= last ? 2'd0 : idx_q + 2'd1;
  end
endmodule
